/* sv/urfd_pkg.sv */
// shared types and constants for the ultrasonic range to fan duty block
package urfd_pkg;

    localparam int MODE_W     = 2;
    localparam int DIST_W     = 9;
    localparam int DUTY_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int DSOR_W     = 9;
    localparam int PROD_W     = 16;

    // item codes
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR    = 2'd3;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
    localparam logic [DIST_W-1:0] RST_MAX   = 9'd22;
    localparam logic [DIST_W-1:0] RST_NEAR  = 9'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT,
        PH_HIGH
    } t_phase;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_DIST,
        CS_DSEL,
        CS_DUTY,
        CS_EMIT
    } t_ctl;

endpackage

/* sv/urfd_in_if.sv */
// input channel: one tick, start or manual duty item per transfer
interface urfd_in_if;
    import urfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic              echo_level;
    logic [DUTY_W-1:0] manual_pct;

    modport source (output valid, mode, echo_level, manual_pct, input ready);
    modport sink   (input valid, mode, echo_level, manual_pct, output ready);
endinterface

/* sv/urfd_out_if.sv */
// output channel: one result per transfer
interface urfd_out_if;
    import urfd_pkg::*;

    logic              valid;
    logic              ready;
    logic              trigger_level;
    logic [DIST_W-1:0] distance_cm;
    logic [DUTY_W-1:0] duty_percent;
    logic              measure_done;
    logic              busy_res;

    modport source (output valid, trigger_level, distance_cm, duty_percent, measure_done,
                    busy_res, input ready);
    modport sink   (input valid, trigger_level, distance_cm, duty_percent, measure_done,
                    busy_res, output ready);
endinterface

/* sv/urfd_sdiv.sv */
// bit-serial restoring divider, one quotient bit per cycle
module urfd_sdiv #(
    parameter int DIVD_W = 16,
    parameter int DSOR_W = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DSOR_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DSOR_W-1:0] r_rem, n_rem;
    logic [DIVD_W-1:0] r_quo, n_quo;
    logic [DSOR_W-1:0] r_dsor, n_dsor;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_done, n_done;

    logic [DSOR_W:0]   w_trial;
    logic [DSOR_W:0]   w_diff;
    logic              w_ge;

    always_comb begin
        w_trial = {r_rem, r_quo[DIVD_W-1]};
        w_ge    = w_trial >= {1'b0, r_dsor};
        w_diff  = w_trial - {1'b0, r_dsor};
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dsor  = r_dsor;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dsor = i_divisor;
            n_cnt  = CNT_W'(DIVD_W);
        end else if (r_cnt != '0) begin
            n_rem  = w_ge ? w_diff[DSOR_W-1:0] : w_trial[DSOR_W-1:0];
            n_quo  = {r_quo[DIVD_W-2:0], w_ge};
            n_cnt  = r_cnt - CNT_W'(1);
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_dsor <= n_dsor;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

/* sv/ultrasonic_range_to_fan_duty_top.sv */
// top level: ultrasonic range measurement driving a fan duty percentage
// Each input transfer is one microsecond tick, a start request, a manual duty write or an
// ignored spare code, and each produces exactly one output transfer showing trigger level,
// last distance, duty, measurement done and busy after that item. An item is accepted and
// then loaded into the output register; in between, the tick on which the echo falls runs the
// shared bit-serial divider for count / CM_DIVISOR and then, in sensor mode between near and
// max, again for distance*100 / max, one quotient bit per cycle over max(COUNT_BITS,16) bits.
// A result still waiting for the sink adds its stall.
// The output register lets a new item be accepted while a result still waits to be taken.
// Registers must be written through the plain write port only while the block is idle; the
// block itself does not enforce this.
module ultrasonic_range_to_fan_duty_top #(
    parameter int TRIGGER_TICKS = 20,
    parameter int CM_DIVISOR    = 58,
    parameter int RANGE_LIMIT   = 400,
    parameter int COUNT_BITS    = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [urfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [urfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    urfd_in_if.sink                       i_in_ch,
    urfd_out_if.source                    o_out_ch
);
    import urfd_pkg::*;

    // divider width covers both the echo count and distance*100
    localparam int DIVD_W = (COUNT_BITS > PROD_W) ? COUNT_BITS : PROD_W;

    // configuration registers
    logic              r_sensor, r_rev;
    logic [DIST_W-1:0] r_max, r_near;

    // measurement state
    t_ctl                r_cs, n_cs;
    t_phase              r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [DIST_W-1:0]   r_dist, n_dist;
    logic [DUTY_W-1:0]   r_duty, n_duty;
    logic                r_pend, n_pend;
    logic                r_done, n_done;

    // output register
    logic                r_out_valid, n_out_valid;
    logic                w_load;
    logic                r_o_trig;
    logic [DIST_W-1:0]   r_o_dist;
    logic [DUTY_W-1:0]   r_o_duty;
    logic                r_o_done;
    logic                r_o_busy;

    // shared divider
    logic                w_div_start;
    logic [DIVD_W-1:0]   w_div_dividend;
    logic [DSOR_W-1:0]   w_div_divisor;
    logic                w_div_done;
    logic [DIVD_W-1:0]   w_div_quo;

    logic                w_in_fire;

    assign i_in_ch.ready = (r_cs == CS_IDLE);
    assign w_in_fire     = i_in_ch.valid && i_in_ch.ready;

    urfd_sdiv #(
        .DIVD_W (DIVD_W),
        .DSOR_W (DSOR_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor <= 1'b1;
            r_rev    <= 1'b0;
            r_max    <= RST_MAX;
            r_near   <= RST_NEAR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SENSOR:  r_sensor <= i_cfg_data[0];
                CFG_REVERSE: r_rev    <= i_cfg_data[0];
                CFG_MAX:     r_max    <= i_cfg_data[DIST_W-1:0];
                CFG_NEAR:    r_near   <= i_cfg_data[DIST_W-1:0];
            endcase
        end
    end

    // item handling and sequencing of the division steps
    always_comb begin
        n_cs           = r_cs;
        n_phase        = r_phase;
        n_count        = r_count;
        n_dist         = r_dist;
        n_duty         = r_duty;
        n_pend         = r_pend;
        n_done         = r_done;
        n_out_valid    = r_out_valid && !o_out_ch.ready;
        w_load         = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = DIVD_W'(r_count);
        w_div_divisor  = DSOR_W'(CM_DIVISOR);

        unique case (r_cs)
            CS_IDLE: begin
                if (w_in_fire) begin
                    n_done = 1'b0;
                    n_cs   = CS_EMIT;
                    unique case (i_in_ch.mode)
                        MODE_START: begin
                            if (r_phase == PH_IDLE) begin
                                n_phase = PH_TRIG;
                                n_count = '0;
                            end
                        end
                        MODE_MANUAL: begin
                            // saturate to full scale, shown at once; reverse waits for echo fall
                            n_duty = (i_in_ch.manual_pct > DUTY_FULL) ? DUTY_FULL
                                                                       : i_in_ch.manual_pct;
                            n_pend = 1'b1;
                        end
                        MODE_TICK: begin
                            unique case (r_phase)
                                PH_IDLE: ;
                                PH_TRIG: begin
                                    if (r_count >= COUNT_BITS'(TRIGGER_TICKS - 1)) begin
                                        n_phase = PH_WAIT;
                                        n_count = '0;
                                    end else begin
                                        n_count = r_count + COUNT_BITS'(1);
                                    end
                                end
                                PH_WAIT: begin
                                    if (i_in_ch.echo_level) begin
                                        n_phase = PH_HIGH;
                                        n_count = COUNT_BITS'(1);
                                    end
                                end
                                PH_HIGH: begin
                                    if (i_in_ch.echo_level) begin
                                        // saturating echo width count
                                        if (r_count != '1) begin
                                            n_count = r_count + COUNT_BITS'(1);
                                        end
                                    end else begin
                                        // echo fell: divider takes the count this edge
                                        w_div_start = 1'b1;
                                        n_phase     = PH_IDLE;
                                        n_count     = '0;
                                        n_done      = 1'b1;
                                        n_cs        = CS_DIST;
                                    end
                                end
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            CS_DIST: begin
                if (w_div_done) begin
                    n_dist = (w_div_quo > DIVD_W'(RANGE_LIMIT)) ? DIST_W'(RANGE_LIMIT)
                                                                : w_div_quo[DIST_W-1:0];
                    n_cs   = CS_DSEL;
                end
            end
            CS_DSEL: begin
                n_cs = CS_EMIT;
                if (r_sensor) begin
                    if (r_dist <= r_near) begin
                        n_duty = r_rev ? '0 : DUTY_FULL;
                    end else if (r_dist >= r_max) begin
                        n_duty = r_rev ? DUTY_FULL : '0;
                    end else begin
                        // strictly between near and max: distance*100 / max
                        w_div_start    = 1'b1;
                        w_div_dividend = DIVD_W'(r_dist) * DIVD_W'(DUTY_FULL);
                        w_div_divisor  = r_max;
                        n_cs           = CS_DUTY;
                    end
                end else if (r_pend) begin
                    n_pend = 1'b0;
                    n_duty = r_rev ? (DUTY_FULL - r_duty) : r_duty;
                end
            end
            CS_DUTY: begin
                if (w_div_done) begin
                    // reversed duty of 100 - q is q itself
                    n_duty = r_rev ? w_div_quo[DUTY_W-1:0]
                                   : (DUTY_FULL - w_div_quo[DUTY_W-1:0]);
                    n_cs   = CS_EMIT;
                end
            end
            CS_EMIT: begin
                if (!r_out_valid || o_out_ch.ready) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_cs        = CS_IDLE;
                end
            end
            default: n_cs = CS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs        <= CS_IDLE;
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_dist      <= '0;
            r_duty      <= '0;
            r_pend      <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cs        <= n_cs;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_dist      <= n_dist;
            r_duty      <= n_duty;
            r_pend      <= n_pend;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    // result snapshot of the state after the item
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_trig <= (r_phase == PH_TRIG);
            r_o_dist <= r_dist;
            r_o_duty <= r_duty;
            r_o_done <= r_done;
            r_o_busy <= (r_phase != PH_IDLE);
        end
    end

    assign o_out_ch.valid         = r_out_valid;
    assign o_out_ch.trigger_level = r_o_trig;
    assign o_out_ch.distance_cm   = r_o_dist;
    assign o_out_ch.duty_percent  = r_o_duty;
    assign o_out_ch.measure_done  = r_o_done;
    assign o_out_ch.busy_res      = r_o_busy;
endmodule

/* sv/urfd_chk.sv */
// port-level checker for the ultrasonic range to fan duty block, with its bind
module urfd_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_trig,
    input logic       i_busy,
    input logic       i_done,
    input logic [6:0] i_duty
);
    // a result waiting for the sink stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result withdrawn before transfer");

    // one item at a time: no second input transfer right after one
    a_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted on consecutive cycles");

    // trigger only shown during a measurement
    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_trig) |-> i_busy)
        else $error("trigger high while not busy");

    // completed measurement leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_done) |-> (!i_busy && !i_trig))
        else $error("measurement done while still busy");

    // duty never exceeds full scale
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_duty <= 7'd100))
        else $error("duty above 100 percent");
endmodule

bind ultrasonic_range_to_fan_duty_top urfd_chk u_urfd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_trig      (o_out_ch.trigger_level),
    .i_busy      (o_out_ch.busy_res),
    .i_done      (o_out_ch.measure_done),
    .i_duty      (o_out_ch.duty_percent)
);

/* tb/tb.sv */
// testbench for the ultrasonic range to fan duty block: items checked against a predictor
module tb;
    import urfd_pkg::*;

    // block parameters, passed to the instance and used by the predictor
    localparam int TRIG_TICKS        = 20;
    localparam int TICKS_PER_CM      = 58;
    localparam int MAX_RANGE_CM      = 400;
    localparam int COUNT_W           = 16;
    localparam int unsigned COUNT_CAP = (1 << COUNT_W) - 1;
    localparam int unsigned FULL_PCT  = 32'(DUTY_FULL);

    // the fourth item code, which the block ignores
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // a little more than the longest item (echo fall with two divisions)
    localparam int     SETTLE_CYCLES = 50;
    localparam longint CYCLE_LIMIT   = 500_000;
    localparam int     SHOWN_MAX     = 10;

    typedef struct packed {
        logic              trigger;
        logic [DIST_W-1:0] distance;
        logic [DUTY_W-1:0] duty;
        logic              done;
        logic              busy;
    } t_reading;

    // predicts the reading after every accepted item and checks the block against it
    class fan_duty_ledger;
        t_phase      phase;
        int unsigned ticks;
        int unsigned last_cm;
        int unsigned duty;
        bit          pending;
        bit          sensor_on;
        bit          reverse_on;
        int unsigned max_cm;
        int unsigned near_cm;
        t_reading    expected_readings[$];
        int          errors;

        function new();
            phase      = PH_IDLE;
            ticks      = 0;
            last_cm    = 0;
            duty       = 0;
            pending    = 1'b0;
            sensor_on  = 1'b1;
            reverse_on = 1'b0;
            max_cm     = 32'(RST_MAX);
            near_cm    = 32'(RST_NEAR);
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SENSOR:  sensor_on  = data[0];
                CFG_REVERSE: reverse_on = data[0];
                CFG_MAX:     max_cm     = 32'(data);
                CFG_NEAR:    near_cm    = 32'(data);
                default: ;
            endcase
        endfunction

        function void note_item(logic [MODE_W-1:0] mode, logic echo, logic [DUTY_W-1:0] manual);
            t_reading    r;
            bit          fell;
            int unsigned cm;
            fell = 1'b0;
            case (mode)
                MODE_START: begin
                    // a start while busy is dropped
                    if (phase == PH_IDLE) begin
                        phase = PH_TRIG;
                        ticks = 0;
                    end
                end
                MODE_MANUAL: begin
                    duty    = (manual > DUTY_FULL) ? FULL_PCT : 32'(manual);
                    pending = 1'b1;
                end
                MODE_TICK: begin
                    case (phase)
                        PH_TRIG: begin
                            ticks++;
                            if (ticks >= TRIG_TICKS) begin
                                phase = PH_WAIT;
                                ticks = 0;
                            end
                        end
                        PH_WAIT: begin
                            if (echo) begin
                                phase = PH_HIGH;
                                ticks = 1;
                            end
                        end
                        PH_HIGH: begin
                            if (echo) begin
                                if (ticks < COUNT_CAP) ticks++;
                            end else begin
                                cm = ticks / TICKS_PER_CM;
                                if (cm > MAX_RANGE_CM) cm = MAX_RANGE_CM;
                                last_cm = cm;
                                if (sensor_on || pending) begin
                                    if (sensor_on) begin
                                        // near test first, no division unless max is above
                                        if (last_cm <= near_cm) duty = FULL_PCT;
                                        else if (last_cm >= max_cm) duty = 0;
                                        else duty = FULL_PCT - (last_cm * FULL_PCT) / max_cm;
                                    end else begin
                                        pending = 1'b0;
                                    end
                                    if (reverse_on) duty = FULL_PCT - duty;
                                end
                                phase = PH_IDLE;
                                ticks = 0;
                                fell  = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            r.trigger  = (phase == PH_TRIG);
            r.distance = last_cm[DIST_W-1:0];
            r.duty     = duty[DUTY_W-1:0];
            r.done     = fell;
            r.busy     = (phase != PH_IDLE);
            expected_readings.push_back(r);
        endfunction

        function void check_reading(t_reading got);
            t_reading want;
            if (expected_readings.size() == 0) begin
                errors++;
                if (errors <= SHOWN_MAX)
                    $display("unexpected: trig %0d dist %0d duty %0d done %0d busy %0d",
                             got.trigger, got.distance, got.duty, got.done, got.busy);
                return;
            end
            want = expected_readings.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= SHOWN_MAX) begin
                    $display("mismatch: expected trig %0d dist %0d duty %0d done %0d busy %0d",
                             want.trigger, want.distance, want.duty, want.done, want.busy);
                    $display("          got      trig %0d dist %0d duty %0d done %0d busy %0d",
                             got.trigger, got.distance, got.duty, got.done, got.busy);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    urfd_in_if  in_ch ();
    urfd_out_if out_ch ();

    fan_duty_ledger ledger;
    bit             quiet = 1'b0;   // when set, neither side idles
    longint         cycles = 0;

    ultrasonic_range_to_fan_duty_top #(
        .TRIGGER_TICKS (TRIG_TICKS),
        .CM_DIVISOR    (TICKS_PER_CM),
        .RANGE_LIMIT   (MAX_RANGE_CM),
        .COUNT_BITS    (COUNT_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic logic rand_echo();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [DUTY_W-1:0] rand_manual();
        return DUTY_W'($urandom_range(0, 127));
    endfunction

    // one input transfer: optional gap, then hold valid until ready is seen at a rising edge
    // valid stays high afterwards, so the caller must follow with another item or lower it
    task automatic send_item(logic [MODE_W-1:0] mode, logic echo, logic [DUTY_W-1:0] manual);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= mode;
        in_ch.echo_level <= echo;
        in_ch.manual_pct <= manual;
        do @(posedge i_clk); while (!in_ch.ready);
        ledger.note_item(mode, echo, manual);
    endtask

    // any item at all; inside an echo pulse ticks are left out so the pulse is not cut short
    task automatic send_noise(bit no_ticks);
        logic [MODE_W-1:0] mode;
        mode = no_ticks ? MODE_W'($urandom_range(1, 3)) : MODE_W'($urandom_range(0, 3));
        send_item(mode, rand_echo(), rand_manual());
    endtask

    // start, trigger ticks, echo low wait, echo high pulse, then the falling tick
    task automatic measure(int unsigned high_ticks, int unsigned wait_ticks,
                           int unsigned trig_ticks, bit noisy);
        send_item(MODE_START, rand_echo(), rand_manual());
        repeat (trig_ticks) begin
            if (noisy && $urandom_range(0, 29) == 0) send_noise(1'b0);
            // echo is of no account during the trigger pulse
            send_item(MODE_TICK, rand_echo(), rand_manual());
        end
        repeat (wait_ticks) send_item(MODE_TICK, 1'b0, rand_manual());
        repeat (high_ticks) begin
            if (noisy && $urandom_range(0, 39) == 0) send_noise(1'b1);
            send_item(MODE_TICK, 1'b1, rand_manual());
        end
        send_item(MODE_TICK, 1'b0, rand_manual());
    endtask

    // bring a measurement left open by noise or a broken sequence to its end
    task automatic settle();
        while (ledger.phase != PH_IDLE)
            send_item(MODE_TICK, ledger.phase == PH_WAIT, rand_manual());
    endtask

    // block idle with every result taken, so registers may be written
    task automatic quiesce();
        settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (ledger.expected_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        ledger.set_reg(idx, data);
    endtask

    // single-bit registers get random upper bits, which the block must ignore
    task automatic write_all(bit sensor, bit reverse, int unsigned max_cm, int unsigned near_cm);
        logic [CFG_DATA_W-2:0] junk;
        junk = (CFG_DATA_W-1)'($urandom_range(0, 255));
        write_reg(CFG_SENSOR, {junk, sensor});
        junk = (CFG_DATA_W-1)'($urandom_range(0, 255));
        write_reg(CFG_REVERSE, {junk, reverse});
        write_reg(CFG_MAX, max_cm[CFG_DATA_W-1:0]);
        write_reg(CFG_NEAR, near_cm[CFG_DATA_W-1:0]);
    endtask

    // result side: random stall before each transfer, sampled at the rising edge
    initial begin : result_sink
        int       stall;
        t_reading got;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 7);
            @(negedge i_clk);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            got.trigger  = out_ch.trigger_level;
            got.distance = out_ch.distance_cm;
            got.duty     = out_ch.duty_percent;
            got.done     = out_ch.measure_done;
            got.busy     = out_ch.busy_res;
            ledger.check_reading(got);
        end
    end

    initial begin : stimulus
        int unsigned cm;
        int unsigned max_pick;

        // every input known from time zero
        in_ch.valid      = 1'b0;
        in_ch.mode       = MODE_TICK;
        in_ch.echo_level = 1'b0;
        in_ch.manual_pct = '0;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_SENSOR;
        i_cfg_data       = '0;
        ledger           = new();

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle items: spare code, stray tick, manual writes incl. saturation above full duty
        send_item(MODE_SPARE, 1'b1, 7'h7F);
        send_item(MODE_TICK, 1'b1, 7'h00);
        send_item(MODE_MANUAL, 1'b0, 7'h7F);
        send_item(MODE_MANUAL, 1'b1, 7'd101);
        send_item(MODE_MANUAL, 1'b0, 7'd0);

        // shortest echo, with starts, a spare code and a manual write landing while busy
        send_item(MODE_START, 1'b1, 7'd0);
        send_item(MODE_START, 1'b0, 7'd0);
        send_item(MODE_SPARE, 1'b0, 7'd0);
        repeat (TRIG_TICKS) send_item(MODE_TICK, 1'b1, 7'd0);
        send_item(MODE_START, 1'b1, 7'd0);
        send_item(MODE_TICK, 1'b1, 7'd0);
        send_item(MODE_MANUAL, 1'b1, 7'd55);
        send_item(MODE_START, 1'b0, 7'd0);
        send_item(MODE_TICK, 1'b0, 7'd0);

        // max boundary at one centimetre, then a count just short of it
        quiesce();
        write_all(1'b1, 1'b0, 1, 0);
        measure(TICKS_PER_CM + 3, 1, TRIG_TICKS, 1'b0);
        measure(TICKS_PER_CM - 1, 0, TRIG_TICKS, 1'b0);

        // reversed: near boundary, then a division by three
        quiesce();
        write_all(1'b1, 1'b1, 3, 1);
        measure(TICKS_PER_CM, 2, TRIG_TICKS, 1'b0);
        quiesce();
        write_all(1'b1, 1'b1, 3, 0);
        measure(TICKS_PER_CM + TICKS_PER_CM / 2, 0, TRIG_TICKS, 1'b0);

        // manual mode: a pending write is reversed once, then the duty is left alone
        quiesce();
        write_all(1'b0, 1'b1, 32'(RST_MAX), 32'(RST_NEAR));
        send_item(MODE_MANUAL, 1'b0, 7'd30);
        measure(1, 0, TRIG_TICKS, 1'b0);
        measure(1, 1, TRIG_TICKS, 1'b0);

        // max below and above its range
        quiesce();
        write_all(1'b1, 1'b1, 0, 0);
        measure(1, 0, TRIG_TICKS, 1'b0);
        quiesce();
        write_all(1'b1, 1'b0, 511, 0);
        measure(TICKS_PER_CM, 0, TRIG_TICKS, 1'b0);

        // random part: small register settings and short echoes
        for (int p = 0; p < 2; p++) begin
            quiesce();
            max_pick = $urandom_range(1, 3);
            write_all($urandom_range(0, 3) != 0, rand_echo(),
                      max_pick, $urandom_range(0, max_pick));
            repeat (2) begin
                quiet = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(5, 20)) send_noise(1'b0);
                end else begin
                    cm = $urandom_range(0, 1);
                    if ($urandom_range(0, 1) != 0)
                        send_item(MODE_MANUAL, rand_echo(), rand_manual());
                    // one in eight sequences has a random trigger length
                    measure(cm * TICKS_PER_CM + $urandom_range(cm == 0 ? 1 : 0, TICKS_PER_CM - 1),
                            $urandom_range(0, 6),
                            ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : TRIG_TICKS,
                            1'b1);
                end
            end
        end

        quiet = 1'b0;
        quiesce();
        if (ledger.errors == 0 && ledger.expected_readings.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

/* files.f */
sv/urfd_pkg.sv
sv/urfd_in_if.sv
sv/urfd_out_if.sv
sv/urfd_sdiv.sv
sv/ultrasonic_range_to_fan_duty_top.sv
sv/urfd_chk.sv
tb/tb.sv
